FILE: design/address_range_allocator_defines.svh
// Assertion helpers for the range allocator
`ifndef ADDRESS_RANGE_ALLOCATOR_DEFINES_SVH
`define ADDRESS_RANGE_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ARA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ARA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ARA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/ara_pkg.sv
`default_nettype none
package ara_pkg;
    localparam int MAX_RANGES_DEF = 64;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int FIELD_W        = 48;

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_ALLOC_AT = 2'd1;
    localparam logic [1:0] OP_FREE     = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [0:0] CFG_POOL_BASE  = 1'b0;
    localparam logic [0:0] CFG_POOL_BYTES = 1'b1;
endpackage
`default_nettype wire

FILE: design/ara_mem.sv
`default_nettype none
module ara_mem #(
    parameter int DEPTH = ara_pkg::MAX_RANGES_DEF,
    parameter int WIDTH = 2 * ara_pkg::ADDR_BITS_DEF + 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: design/address_range_allocator.sv
// First-fit range allocator. A request is taken when start is high and busy low; one
// cycle-wide o_valid strobe later carries status, address and bytes in use, and it
// cannot be held off, so the receiver must take it in that cycle. A request keeps busy
// high while entries are scanned and moved, so a new request is taken only after it
// ends: the range table sits in one memory with one read and one write port,
// scanned one entry a cycle and shifted one entry a cycle on a split or merge. Writing
// pool_base or pool_bytes resets the table at that edge; do so only while busy is low
// and no result is pending.
`default_nettype none
`include "address_range_allocator_defines.svh"
module address_range_allocator #(
    parameter int MAX_RANGES = ara_pkg::MAX_RANGES_DEF,
    parameter int ADDR_BITS  = ara_pkg::ADDR_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [47:0] i_request_address,
    input  wire logic [47:0] i_request_size,
    input  wire logic [5:0]  i_align_log2,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [47:0]      o_result_address,
    output logic [47:0]      o_used_bytes
);
    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = 2 * AW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CARVE1, S_CARVE2, S_MERGE1, S_MERGE2, S_SHIFT, S_WRITE, S_DONE
    } t_state;

    t_state         r_state;
    logic [AW-1:0]  r_pool_base, r_pool_bytes, r_eff_len, r_used;
    logic [CW-1:0]  r_count;
    logic [1:0]     r_op;
    logic [AW-1:0]  r_addr, r_size;
    logic [5:0]     r_al;
    logic [IW-1:0]  r_idx;
    logic [AW-1:0]  r_s, r_l, r_off, r_rem, r_tail, r_gaddr, r_mlen;
    logic [AW-1:0]  r_prev_start, r_prev_len;
    logic           r_prev_free, r_nf;
    logic [1:0]     r_need;
    logic [EW-1:0]  r_q [3];
    logic [1:0]     r_qn, r_wj;
    logic [IW-1:0]  r_wpos;
    logic           r_dir_up;
    logic [1:0]     r_d;
    logic [IW-1:0]  r_src, r_pdst;
    logic [CW-1:0]  r_nsrc;
    logic           r_pend;
    logic           r_valid;
    logic [2:0]     r_status;
    logic [AW-1:0]  r_res;

    // memory ports
    logic           mem_we;
    logic [IW-1:0]  mem_waddr, mem_raddr;
    logic [EW-1:0]  mem_wdata, rd;
    logic [AW-1:0]  rd_start, rd_len;
    logic           rd_free;

    // request and configuration fields at the internal width
    logic [63:0]    addr_x, size_x, cfg_x, res_x, used_x;
    logic [AW-1:0]  addr_in, size_in, cfg_in;
    logic [AW-1:0]  n_base, n_bytes, n_len;

    // scan match
    logic           al_big, huge, below, fit, m_alloc, m_free;
    logic [AW-1:0]  amask, off, rem, tail_c;
    logic           pf, nf_c;

    assign addr_x  = 64'(i_request_address);
    assign size_x  = 64'(i_request_size);
    assign cfg_x   = 64'(i_cfg_data);
    assign addr_in = addr_x[AW-1:0];
    assign size_in = size_x[AW-1:0];
    assign cfg_in  = cfg_x[AW-1:0];

    assign rd_start = rd[AW-1:0];
    assign rd_len   = rd[2*AW-1:AW];
    assign rd_free  = rd[2*AW];

    always_comb begin
        n_base  = (i_cfg_index == ara_pkg::CFG_POOL_BASE)  ? cfg_in : r_pool_base;
        n_bytes = (i_cfg_index == ara_pkg::CFG_POOL_BYTES) ? cfg_in : r_pool_bytes;
        // clip a pool that runs past the top of the address space
        n_len   = (n_bytes > ~n_base) ? (~n_base + AW'(1)) : n_bytes;
    end

    always_comb begin
        al_big  = {1'b0, r_al} >= 7'(AW);
        amask   = al_big ? '1 : ((AW'(1) << r_al) - AW'(1));
        huge    = al_big && (rd_start != '0);
        below   = r_addr < rd_start;
        off     = (r_op == ara_pkg::OP_ALLOC) ? ((~rd_start + AW'(1)) & amask)
                                              : (r_addr - rd_start);
        rem     = rd_len - off;
        fit     = (off <= rd_len) && (r_size <= rem);
        m_alloc = rd_free && fit && ((r_op == ara_pkg::OP_ALLOC) ? !huge : !below);
        m_free  = !rd_free && (rd_start == r_addr);
        tail_c  = r_rem - r_size;
        nf_c    = ((CW'(r_idx) + CW'(1)) < r_count) && rd_free;
        pf      = (r_idx != '0) && r_prev_free;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_q[r_wj];
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                mem_we    = i_cfg_we;
                mem_wdata = {1'b1, n_len, n_base};
            end
            S_SCAN:  mem_raddr = r_idx + IW'(1);
            S_SHIFT: begin
                mem_raddr = r_src;
                mem_we    = r_pend;
                mem_waddr = r_pdst;
                mem_wdata = rd;
            end
            S_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = r_wpos + IW'(r_wj);
            end
            default: ;
        endcase
    end

    ara_mem #(.DEPTH(MAX_RANGES), .WIDTH(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_base  <= '0;
            r_pool_bytes <= '0;
            r_eff_len    <= '0;
            r_used       <= '0;
            r_count      <= '0;
            r_valid      <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_pool_base  <= n_base;
                        r_pool_bytes <= n_bytes;
                        r_eff_len    <= n_len;
                        r_used       <= '0;
                        r_count      <= (n_len != '0) ? CW'(1) : '0;
                    end
                    if (start) begin
                        r_op    <= i_opcode;
                        r_addr  <= addr_in;
                        r_size  <= size_in;
                        r_al    <= i_align_log2;
                        r_idx   <= '0;
                        r_res   <= '0;
                        r_state <= S_DONE;
                        case (i_opcode)
                            ara_pkg::OP_ALLOC, ara_pkg::OP_ALLOC_AT: begin
                                if (size_in == '0 || r_count == '0) begin
                                    r_status <= ara_pkg::ST_BAD;
                                end else if (i_opcode == ara_pkg::OP_ALLOC_AT &&
                                             (addr_in < r_pool_base ||
                                              addr_in - r_pool_base >= r_eff_len)) begin
                                    r_status <= ara_pkg::ST_BAD;
                                end else begin
                                    r_status <= ara_pkg::ST_NOSPACE;
                                    r_state  <= S_SCAN;
                                end
                            end
                            ara_pkg::OP_FREE: begin
                                r_status <= ara_pkg::ST_NOTALLOC;
                                if (r_count != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: r_status <= ara_pkg::ST_BAD;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_op != ara_pkg::OP_FREE && m_alloc) begin
                        r_s     <= rd_start;
                        r_off   <= off;
                        r_rem   <= rem;
                        r_state <= S_CARVE1;
                    end else if (r_op == ara_pkg::OP_FREE && m_free) begin
                        r_s     <= rd_start;
                        r_l     <= rd_len;
                        r_used  <= r_used - rd_len;
                        r_state <= S_MERGE1;
                    end else begin
                        r_prev_start <= rd_start;
                        r_prev_len   <= rd_len;
                        r_prev_free  <= rd_free;
                        if (CW'(r_idx) == r_count - CW'(1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_CARVE1: begin
                    r_tail  <= tail_c;
                    r_gaddr <= r_s + r_off;
                    r_need  <= 2'(r_off != '0) + 2'(tail_c != '0);
                    r_state <= S_CARVE2;
                end
                S_CARVE2: begin
                    if ((CW+1)'(r_count) + (CW+1)'(r_need) > (CW+1)'(MAX_RANGES)) begin
                        r_status <= ara_pkg::ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        if (r_off != '0) begin
                            r_q[0] <= {1'b1, r_off, r_s};
                            r_q[1] <= {1'b0, r_size, r_gaddr};
                            r_q[2] <= {1'b1, r_tail, r_gaddr + r_size};
                        end else begin
                            r_q[0] <= {1'b0, r_size, r_gaddr};
                            r_q[1] <= {1'b1, r_tail, r_gaddr + r_size};
                            r_q[2] <= r_q[2];
                        end
                        r_qn     <= r_need;
                        r_wpos   <= r_idx;
                        r_used   <= r_used + r_size;
                        r_count  <= r_count + CW'(r_need);
                        r_res    <= r_gaddr;
                        r_status <= ara_pkg::ST_OK;
                        // entries above the split move up by the number of new entries
                        r_dir_up <= 1'b1;
                        r_d      <= r_need;
                        r_src    <= IW'(r_count - CW'(1));
                        r_nsrc   <= (r_need == 2'd0) ? '0
                                    : r_count - CW'(r_idx) - CW'(1);
                        r_pend   <= 1'b0;
                        r_state  <= S_SHIFT;
                    end
                end
                S_MERGE1: begin
                    r_nf    <= nf_c;
                    r_mlen  <= r_l + (nf_c ? rd_len : '0);
                    r_state <= S_MERGE2;
                end
                S_MERGE2: begin
                    r_q[0]   <= pf ? {1'b1, r_mlen + r_prev_len, r_prev_start}
                                   : {1'b1, r_mlen, r_s};
                    r_wpos   <= pf ? r_idx - IW'(1) : r_idx;
                    r_qn     <= '0;
                    r_count  <= r_count - CW'(r_nf) - CW'(pf);
                    r_status <= ara_pkg::ST_OK;
                    r_dir_up <= 1'b0;
                    r_d      <= 2'(r_nf) + 2'(pf);
                    r_src    <= r_idx + IW'(1) + IW'(r_nf);
                    r_nsrc   <= (!r_nf && !pf) ? '0
                                : r_count - CW'(r_idx) - CW'(1) - CW'(r_nf);
                    r_pend   <= 1'b0;
                    r_state  <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (r_nsrc != '0) begin
                        r_pend <= 1'b1;
                        r_pdst <= r_dir_up ? r_src + IW'(r_d) : r_src - IW'(r_d);
                        r_src  <= r_dir_up ? r_src - IW'(1) : r_src + IW'(1);
                        r_nsrc <= r_nsrc - CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_wj    <= '0;
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_wj <= r_wj + 2'd1;
                    if (r_wj == r_qn) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign res_x            = 64'(r_res);
    assign used_x           = 64'(r_used);
    assign o_result_address = res_x[47:0];
    assign o_used_bytes     = used_x[47:0];

    `ARA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    `ARA_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    `ARA_ASSERT_SAME(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_RANGES), "table over")
    `ARA_ASSERT_NEXT(a_shift_end, i_clk, i_rst_n, r_state == S_SHIFT && r_nsrc == '0 && !r_pend, r_state == S_WRITE, "no write-back")
endmodule
`default_nettype wire
